### hdl/waypoint_path_follower_unit_defines.svh
// assertion macros for the path follower unit
`ifndef WAYPOINT_PATH_FOLLOWER_UNIT_DEFINES_SVH
`define WAYPOINT_PATH_FOLLOWER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define WPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPF_ASSERT(label, prop, msg)
`define WPF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hdl/wpf_pkg.sv
`timescale 1ns / 1ps
package wpf_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 32;
    localparam int TRAVEL_W   = 48;
    localparam int PROD_W     = 64;
    localparam int ROOT_W     = PROD_W / 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] SPEED_RESET = 32'h0001_0000;

    // item kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // path modes
    localparam logic [1:0] MODE_ONCE    = 2'd0;
    localparam logic [1:0] MODE_REPEAT  = 2'd1;
    localparam logic [1:0] MODE_PATROL  = 2'd2;
    localparam logic [1:0] MODE_POLYGON = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_HEIGHT = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        elapsed;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [3:0]         target_index;
        logic               finished;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RESTART_RD,
        ST_RESTART_SET,
        ST_TGT_RD,
        ST_ARRIVE,
        ST_JUMP_RD,
        ST_JUMP_SET,
        ST_FETCH_RD,
        ST_FETCH_SET,
        ST_TRAVEL_GO,
        ST_TRAVEL_WAIT,
        ST_DIFF,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_CHECK,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_STEP,
        ST_EMIT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

### hdl/wpf_mul.sv
`timescale 1ns / 1ps
module wpf_mul
    import wpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TRAVEL_W-1:0] mcand,
    input  logic [COORD_W-1:0]  mplier,
    output logic                done,
    output logic [PROD_W-1:0]   product
);

    // shift-add multiplier, one multiplier bit per cycle
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]  shift_reg, shift_next;
    logic [COORD_W-1:0] mplier_reg, mplier_next;
    logic [5:0]         count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            shift_next  = PROD_W'(mcand);
            mplier_next = mplier;
            count_next  = 6'(COORD_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + shift_reg;
            end
            shift_next  = {shift_reg[PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[COORD_W-1:1]};
            count_next  = count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        shift_reg  <= shift_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hdl/wpf_sqrt.sv
`timescale 1ns / 1ps
module wpf_sqrt
    import wpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    // digit-by-digit square root, two radicand bits per cycle
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [PROD_W-1:0] src_reg, src_next;
    logic [5:0]        count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+2:0] rem_try;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] rem_sub;

    always_comb
    begin
        rem_try    = {rem_reg[ROOT_W:0], src_reg[PROD_W-1:PROD_W-2]};
        trial      = {1'b0, root_reg, 2'b01};
        rem_sub    = rem_try - trial;
        rem_next   = rem_reg;
        root_next  = root_reg;
        src_next   = src_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            root_next  = '0;
            src_next   = radicand;
            count_next = 6'(ROOT_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_try >= trial)
            begin
                rem_next  = rem_sub[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_try[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            src_next   = {src_reg[PROD_W-3:0], 2'b00};
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hdl/wpf_div.sv
`timescale 1ns / 1ps
module wpf_div
    import wpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [ROOT_W-1:0] divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    // restoring divider, one quotient bit per cycle
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quot_reg, quot_next;
    logic [ROOT_W-1:0] div_reg, div_next;
    logic [6:0]        count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W:0]   rem_try;
    logic [ROOT_W:0]   rem_sub;
    logic              fits;

    always_comb
    begin
        rem_try    = {rem_reg, quot_reg[PROD_W-1]};
        rem_sub    = rem_try - {1'b0, div_reg};
        fits       = (rem_try >= {1'b0, div_reg});
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        div_next   = div_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            quot_next  = dividend;
            div_next   = divisor;
            count_next = 7'(PROD_W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? rem_sub[ROOT_W-1:0] : rem_try[ROOT_W-1:0];
            quot_next  = {quot_reg[PROD_W-2:0], fits};
            count_next = count_reg - 7'd1;
            if (count_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### hdl/waypoint_path_follower_unit.sv
`timescale 1ns / 1ps
// Waypoint path follower: holds up to 16 waypoints and a position in signed Q16.16 and moves
// the position toward the current target at speed times elapsed per tick item. A load item
// is written into the waypoint store and gives no result; a restart item reads waypoint 0
// into the position and then gives its result. A tick item ends early when the path has ended
// or the travel is zero; otherwise it forms speed times elapsed, the squared differences, their
// square root and, when the target lies farther than one step, a multiply and a divide per axis.
// These steps use the one shared bit-serial multiplier, the bit-serial root unit and
// the 64-step divider, each settling one bit per cycle. Input items are taken only while the
// unit is idle; a finished result waits in the output register while the next item is already
// accepted.
`include "waypoint_path_follower_unit_defines.svh"
module waypoint_path_follower_unit
    import wpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    state_t state_reg, state_next;

    logic [31:0]        speed_reg;
    logic [1:0]         mode_reg;
    logic [4:0]         count_cfg_reg;
    logic               flat_reg;
    logic signed [31:0] flat_height_reg;

    logic [3*COORD_W-1:0] wp_mem [MAX_POINTS];
    logic [3*COORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;

    in_item_t           item_reg, item_next;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] wp_reg [3];
    logic signed [31:0] wp_next [3];
    logic signed [31:0] diff_reg [3];
    logic signed [31:0] diff_next [3];
    logic signed [31:0] rd_coord [3];
    logic [IDX_W-1:0]   target_reg, target_next;
    logic               back_reg, back_next;
    logic               done_reg, done_next;
    logic [TRAVEL_W-1:0] travel_reg, travel_next;
    logic [PROD_W-1:0]  sum_reg, sum_next;
    logic [ROOT_W-1:0]  dist_reg, dist_next;
    logic [1:0]         axis_reg, axis_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic                in_accept;
    logic                out_free;
    logic                arrived;
    logic                at_end;
    logic [4:0]          count_used;
    logic [IDX_W-1:0]    last_idx;
    logic [31:0]         mag_sel;
    logic signed [34:0]  pos_wide;
    logic signed [34:0]  delta_wide;

    logic                mul_start;
    logic [TRAVEL_W-1:0] mul_a;
    logic [COORD_W-1:0]  mul_b;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_product;
    logic                root_start;
    logic                root_done;
    logic [ROOT_W-1:0]   root_value;
    logic                div_start;
    logic                div_done;
    logic [PROD_W-1:0]   div_quot;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mem_we    = in_accept && (in_data.kind == KIND_LOAD);

    // waypoints in use, clamped to the supported range
    assign count_used = (count_cfg_reg < 5'd2) ? 5'd2 :
                        (count_cfg_reg > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : count_cfg_reg;
    assign last_idx   = IDX_W'(count_used - 5'd1);
    assign at_end     = (target_reg >= last_idx);

    assign rd_coord[0] = rd_data_reg[3*COORD_W-1:2*COORD_W];
    assign rd_coord[1] = rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_coord[2] = rd_data_reg[COORD_W-1:0];
    assign arrived     = (rd_coord[0] == pos_reg[0]) && (rd_coord[1] == pos_reg[1]) &&
                         (rd_coord[2] == pos_reg[2]);

    assign mag_sel = mag32(diff_reg[axis_reg]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg       <= SPEED_RESET;
            mode_reg        <= MODE_ONCE;
            count_cfg_reg   <= 5'd2;
            flat_reg        <= 1'b0;
            flat_height_reg <= '0;
        end
        else if (write_en)
        begin
            unique case (write_index)
                CFG_SPEED:       speed_reg       <= write_data;
                CFG_PATH_MODE:   mode_reg        <= write_data[1:0];
                CFG_POINT_COUNT: count_cfg_reg   <= write_data[4:0];
                CFG_FLAT_MODE:   flat_reg        <= write_data[0];
                CFG_FLAT_HEIGHT: flat_height_reg <= write_data;
                default:         ;
            endcase
        end
    end

    // waypoint store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wp_mem[in_data.point_index] <= {in_data.coord_x, in_data.coord_y,
                                            flat_reg ? flat_height_reg : in_data.coord_z};
        end
        rd_data_reg <= wp_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.kind == KIND_RESTART)
                    begin
                        state_next = ST_RESTART_RD;
                    end
                    else if (in_data.kind == KIND_TICK)
                    begin
                        state_next = ST_TGT_RD;
                    end
                end
            end
            ST_RESTART_RD:  state_next = ST_RESTART_SET;
            ST_RESTART_SET: state_next = ST_EMIT;
            ST_TGT_RD:      state_next = ST_ARRIVE;
            ST_ARRIVE:
            begin
                state_next = ST_FETCH_RD;
                if (arrived && at_end)
                begin
                    if (mode_reg == MODE_ONCE)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (mode_reg == MODE_REPEAT)
                    begin
                        state_next = ST_JUMP_RD;
                    end
                end
            end
            ST_JUMP_RD:     state_next = ST_JUMP_SET;
            ST_JUMP_SET:    state_next = ST_FETCH_RD;
            ST_FETCH_RD:    state_next = ST_FETCH_SET;
            ST_FETCH_SET:   state_next = ST_TRAVEL_GO;
            ST_TRAVEL_GO:   state_next = ST_TRAVEL_WAIT;
            ST_TRAVEL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (mul_product[TRAVEL_W-1:0] == '0) ? ST_EMIT : ST_DIFF;
                end
            end
            ST_DIFF:        state_next = ST_SQ_GO;
            ST_SQ_GO:       state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_ROOT_GO : ST_SQ_GO;
                end
            end
            ST_ROOT_GO:     state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (TRAVEL_W'(dist_reg) < travel_reg) ? ST_EMIT : ST_SCALE_GO;
            end
            ST_SCALE_GO:    state_next = ST_SCALE_WAIT;
            ST_SCALE_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:        state_next = (axis_reg == 2'd2) ? ST_EMIT : ST_SCALE_GO;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall   = 1'b1;
        rd_addr    = target_reg;
        mul_start  = 1'b0;
        mul_a      = travel_reg;
        mul_b      = mag_sel;
        root_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:       in_stall = 1'b0;
            ST_RESTART_RD: rd_addr = '0;
            ST_JUMP_RD:    rd_addr = '0;
            ST_TRAVEL_GO:
            begin
                mul_start = 1'b1;
                mul_a     = TRAVEL_W'(speed_reg);
                mul_b     = COORD_W'(item_reg.elapsed);
            end
            ST_SQ_GO:
            begin
                mul_start = 1'b1;
                mul_a     = TRAVEL_W'(mag_sel);
            end
            ST_ROOT_GO:    root_start = 1'b1;
            ST_SCALE_GO:   mul_start = 1'b1;
            ST_DIV_GO:     div_start = 1'b1;
            default:       ;
        endcase
    end

    // datapath
    always_comb
    begin
        item_next      = item_reg;
        pos_next       = pos_reg;
        wp_next        = wp_reg;
        diff_next      = diff_reg;
        target_next    = target_reg;
        back_next      = back_reg;
        done_next      = done_reg;
        travel_next    = travel_reg;
        sum_next       = sum_reg;
        dist_next      = dist_reg;
        axis_next      = axis_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        pos_wide       = {{3{pos_reg[axis_reg][31]}}, pos_reg[axis_reg]};
        delta_wide     = diff_reg[axis_reg][31] ? -$signed({1'b0, div_quot[33:0]})
                                                :  $signed({1'b0, div_quot[33:0]});
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_next = in_data;
                end
            end
            ST_RESTART_SET:
            begin
                pos_next    = rd_coord;
                target_next = IDX_W'(1);
                back_next   = 1'b0;
                done_next   = 1'b0;
            end
            ST_ARRIVE:
            begin
                done_next = 1'b0;
                if (arrived)
                begin
                    if (at_end)
                    begin
                        case (mode_reg)
                            MODE_POLYGON: target_next = '0;
                            MODE_PATROL:
                            begin
                                back_next   = 1'b1;
                                target_next = target_reg - IDX_W'(1);
                            end
                            MODE_REPEAT:  target_next = IDX_W'(1);
                            default:      done_next = 1'b1;
                        endcase
                    end
                    else if (back_reg)
                    begin
                        if (target_reg == '0)
                        begin
                            back_next   = 1'b0;
                            target_next = IDX_W'(1);
                        end
                        else
                        begin
                            target_next = target_reg - IDX_W'(1);
                        end
                    end
                    else
                    begin
                        target_next = target_reg + IDX_W'(1);
                    end
                end
            end
            ST_JUMP_SET:  pos_next = rd_coord;
            ST_FETCH_SET: wp_next = rd_coord;
            ST_TRAVEL_WAIT:
            begin
                if (mul_done)
                begin
                    travel_next = mul_product[TRAVEL_W-1:0];
                end
            end
            ST_DIFF:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    diff_next[a] = sat32(35'(wp_reg[a]) - 35'(pos_reg[a]));
                end
                sum_next  = '0;
                axis_next = '0;
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    sum_next  = sum_reg + mul_product;
                    axis_next = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                end
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    dist_next = root_value;
                end
            end
            ST_CHECK:
            begin
                // closer than one step: land on the target
                if (TRAVEL_W'(dist_reg) < travel_reg)
                begin
                    pos_next = wp_reg;
                end
            end
            ST_STEP:
            begin
                pos_next[axis_reg] = sat32(pos_wide + delta_wide);
                axis_next          = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.pos_x        = pos_reg[0];
                    out_data_next.pos_y        = pos_reg[1];
                    out_data_next.pos_z        = pos_reg[2];
                    out_data_next.target_index = target_reg;
                    out_data_next.finished     = done_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '{default: '0};
            target_reg    <= IDX_W'(1);
            back_reg      <= 1'b0;
            done_reg      <= 1'b0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            back_reg      <= back_next;
            done_reg      <= done_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        wp_reg       <= wp_next;
        diff_reg     <= diff_next;
        travel_reg   <= travel_next;
        sum_reg      <= sum_next;
        dist_reg     <= dist_next;
        out_data_reg <= out_data_next;
    end

    wpf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    wpf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root_value)
    );

    wpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (dist_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // scaling only runs when the step is no longer than the distance
    `WPF_ASSERT(a_scale_bound, (state_reg == ST_STEP) |-> (div_quot[PROD_W-1:ROOT_W] == '0), "step quotient too wide")
    `WPF_ASSERT(a_mul_owner, mul_done |-> (state_reg == ST_TRAVEL_WAIT || state_reg == ST_SQ_WAIT || state_reg == ST_SCALE_WAIT), "multiplier done outside a wait state")
    `WPF_ASSERT(a_emit, (state_reg == ST_EMIT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE), "result not posted")
    `WPF_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "result valid during reset")

endmodule
